>>> rtl/tplru_pkg.sv
// Shared types, constants and tree helper functions for the pseudo-LRU replacement block.
package tplru_pkg;

    localparam int WAYS         = 8;
    localparam int WAY_W        = 3;
    localparam int LEVELS       = 3;
    localparam int NODES        = WAYS - 1;
    localparam int NODE_W       = 3;
    localparam int CNT_W        = $clog2(WAYS + 1);
    localparam int SET_IN_W     = 6;
    localparam int MASK_W       = 8;
    localparam int THR_W        = 4;
    localparam int NUM_SETS_DEF = 64;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = 1;

    localparam logic [THR_W-1:0]  THR_RESET = 4'd4;
    localparam logic [MASK_W-1:0] ALL_WAYS  = '1;

    localparam logic [1:0] KIND_TOUCH = 2'd0;
    localparam logic [1:0] KIND_INVAL = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    typedef logic [NODES-1:0] t_tree;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SET_IN_W-1:0] set;
        logic [WAY_W-1:0]    way;
        logic [MASK_W-1:0]   mask;
    } t_op;

    typedef struct packed {
        logic [WAY_W-1:0] victim;
        logic             over;
    } t_result;

    // Sets each node on the leaf's path to point toward the leaf, or away from it.
    function automatic t_tree mark_path(t_tree tree, logic [WAY_W-1:0] way, logic toward);
        int unsigned n;
        int unsigned p;
        logic        from_right;
        t_tree       t;
        t = tree;
        n = int'(way) + NODES;
        for (int l = 0; l < LEVELS; l++) begin
            from_right = (n[0] == 1'b0);
            p = (n - 1) >> 1;
            t[p[NODE_W-1:0]] = toward ? from_right : !from_right;
            n = p;
        end
        return t;
    endfunction

    // Follows the node bits from the root down to a leaf.
    function automatic logic [WAY_W-1:0] walk(t_tree tree);
        int unsigned n;
        n = 0;
        for (int l = 0; l < LEVELS; l++) begin
            n = tree[n[NODE_W-1:0]] ? 2 * n + 2 : 2 * n + 1;
        end
        return WAY_W'(n - NODES);
    endfunction

    function automatic logic [CNT_W-1:0] popcount(logic [MASK_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < MASK_W; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

>>> rtl/tplru_front.sv
// Front end: takes command words, drops reserved kinds and folds the set index.
module tplru_front #(
    parameter int NUM_SETS = tplru_pkg::NUM_SETS_DEF
) (
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_kind,
    input  logic [tplru_pkg::SET_IN_W-1:0] i_set_index,
    input  logic [tplru_pkg::WAY_W-1:0]   i_way,
    input  logic [tplru_pkg::MASK_W-1:0]  i_preserve_mask,
    input  logic                          i_q_full,
    input  logic                          i_clearing,
    output logic                          o_busy,
    output logic                          o_push,
    output tplru_pkg::t_op                o_op
);
    import tplru_pkg::*;

    localparam int SET_SPAN = 1 << SET_IN_W;

    function automatic logic [SET_SPAN*SET_IN_W-1:0] build_mod_tbl();
        logic [SET_SPAN*SET_IN_W-1:0] t;
        t = '0;
        for (int i = 0; i < SET_SPAN; i++) begin
            t[i*SET_IN_W +: SET_IN_W] = SET_IN_W'(i % NUM_SETS);
        end
        return t;
    endfunction

    localparam logic [SET_SPAN*SET_IN_W-1:0] MOD_TBL = build_mod_tbl();

    logic accept;

    assign o_busy = !i_rst_n || i_q_full || i_clearing;
    assign accept = i_start && !o_busy;
    assign o_push = accept && (i_kind != KIND_RSVD);

    always_comb begin
        o_op.kind = i_kind;
        o_op.set  = MOD_TBL[int'(i_set_index)*SET_IN_W +: SET_IN_W];
        o_op.way  = i_way;
        o_op.mask = i_preserve_mask;
    end

endmodule

>>> rtl/tplru_queue.sv
// Two-entry command queue between the front end and the tree engine.
module tplru_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tplru_pkg::t_op i_op,
    input  logic           i_pop,
    output tplru_pkg::t_op o_op,
    output logic           o_full,
    output logic           o_empty
);
    import tplru_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic [Q_PTR_W-1:0] n_wp;
    logic [Q_PTR_W-1:0] n_rp;
    logic [Q_PTR_W:0]   n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/tplru_back.sv
// Tree engine: holds the per-set trees, applies updates and runs the victim search.
module tplru_back #(
    parameter int NUM_SETS = tplru_pkg::NUM_SETS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tplru_pkg::t_op              i_op,
    input  logic                        i_q_empty,
    input  logic [tplru_pkg::THR_W-1:0] i_thr,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_res_valid,
    output tplru_pkg::t_result          o_res
);
    import tplru_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_SEARCH = 2'd3;

    t_tree            r_mem [NUM_SETS];
    t_tree            r_rdata;
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [SET_W-1:0] r_clr;
    logic [SET_W-1:0] n_clr;
    t_op              r_op;
    t_op              n_op;
    t_tree            r_scratch;
    t_tree            n_scratch;
    logic [WAY_W-1:0] r_plain;
    logic [WAY_W-1:0] n_plain;
    logic [CNT_W-1:0] r_tries;
    logic [CNT_W-1:0] n_tries;
    logic             r_valid;
    logic             n_valid;
    t_result          r_res;
    t_result          n_res;

    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [SET_W-1:0] mem_raddr;
    t_tree            mem_wdata;
    t_tree            walk_tree;
    logic [WAY_W-1:0] w;
    logic [CNT_W-1:0] cnt;

    assign mem_raddr   = SET_W'(i_op.set);
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_op      = r_op;
        n_scratch = r_scratch;
        n_plain   = r_plain;
        n_tries   = r_tries;
        n_valid   = 1'b0;
        n_res     = r_res;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = SET_W'(r_op.set);
        mem_wdata = mark_path(r_rdata, r_op.way, r_op.kind == KIND_INVAL);
        walk_tree = (r_state == ST_READ) ? r_rdata : r_scratch;
        w         = walk(walk_tree);
        cnt       = popcount(r_op.mask);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == LAST_SET) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_op    = i_op;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_op.kind == KIND_QUERY) begin
                    n_plain   = w;
                    n_scratch = r_rdata;
                    n_tries   = '0;
                    if (cnt > CNT_W'(i_thr)) begin
                        n_valid      = 1'b1;
                        n_res.victim = w;
                        n_res.over   = 1'b1;
                        n_state      = ST_IDLE;
                    end else if (r_op.mask == ALL_WAYS) begin
                        n_valid      = 1'b1;
                        n_res.victim = w;
                        n_res.over   = 1'b0;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end else begin
                    mem_we  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                // Preserved ways found by the walk are touched in the scratch tree only.
                if (r_tries == CNT_W'(WAYS)) begin
                    n_valid      = 1'b1;
                    n_res.victim = r_plain;
                    n_res.over   = 1'b0;
                    n_state      = ST_IDLE;
                end else if (r_op.mask[w]) begin
                    n_scratch = mark_path(r_scratch, w, 1'b0);
                    n_tries   = r_tries + 1'b1;
                end else begin
                    n_valid      = 1'b1;
                    n_res.victim = w;
                    n_res.over   = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_scratch <= n_scratch;
        r_plain   <= n_plain;
        r_tries   <= n_tries;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

endmodule

>>> rtl/tree_plru_preserve_replacement.sv
// Top level of the tree pseudo-LRU replacement block with way preservation.
//
// Commands enter on start/busy: a word is taken at a clock edge where start is high
// and busy is low. Kind 0 touches a way, kind 1 invalidates it, kind 2 asks for a
// victim in the given set using the preserve mask; kind 3 is taken and dropped.
// Touches and invalidates give no result. A query gives one result on
// o_victim_way/o_over_threshold, marked by o_valid for one cycle; there is no
// backpressure on results.
// The user must write the preserve threshold through i_cfg_we/i_cfg_wdata only while
// idle; the block itself does not enforce this. A two-entry queue decouples the
// command port from the tree engine, so busy rises only when that queue is full.
// Each command is popped in the engine's idle state, which also reads its set's tree,
// and then the read state applies the update or runs the plain walk. A query that
// needs the preserved search walks the scratch tree in the search state, touching
// preserved ways, until a walk ends on an unpreserved way or WAYS tries fall back
// to the plain victim. After reset the tree memory is cleared one set per cycle, all
// NUM_SETS sets, with busy held high; the threshold returns to 4.
module tree_plru_preserve_replacement #(
    parameter int NUM_SETS = tplru_pkg::NUM_SETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_kind,
    input  logic [tplru_pkg::SET_IN_W-1:0] i_set_index,
    input  logic [tplru_pkg::WAY_W-1:0]    i_way,
    input  logic [tplru_pkg::MASK_W-1:0]   i_preserve_mask,
    input  logic                           i_cfg_we,
    input  logic [tplru_pkg::THR_W-1:0]    i_cfg_wdata,
    output logic                           o_valid,
    output logic [tplru_pkg::WAY_W-1:0]    o_victim_way,
    output logic                           o_over_threshold
);
    import tplru_pkg::*;

    logic [THR_W-1:0] r_thr;
    t_op              push_op;
    t_op              head_op;
    t_result          res;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic             clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    tplru_front #(.NUM_SETS(NUM_SETS)) u_front (
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_kind          (i_kind),
        .i_set_index     (i_set_index),
        .i_way           (i_way),
        .i_preserve_mask (i_preserve_mask),
        .i_q_full        (q_full),
        .i_clearing      (clearing),
        .o_busy          (busy),
        .o_push          (push),
        .o_op            (push_op)
    );

    tplru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tplru_back #(.NUM_SETS(NUM_SETS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (head_op),
        .i_q_empty   (q_empty),
        .i_thr       (r_thr),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_res_valid (o_valid),
        .o_res       (res)
    );

    assign o_victim_way     = res.victim;
    assign o_over_threshold = res.over;

endmodule

>>> rtl/tplru_checker.sv
// Port-level checks for the pseudo-LRU replacement block, bound to the top level.
module tplru_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // The engine needs at least a read cycle between two results.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe on two consecutive cycles");

    // Reset starts the clearing pass and drops any pending strobe.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_valid))
        else $error("busy low or strobe high right after reset");

    // Busy goes high only from reset or from a command filling the queue.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) || $past(!i_rst_n)))
        else $error("busy rose without a command or reset");

endmodule

bind tree_plru_preserve_replacement tplru_checker u_tplru_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
